FILE: rtl/bsad_pkg.sv
package bsad_pkg;

   localparam int MODE_W = 5;
   localparam int ADDR_W = 16;

   // banking line positions in the mode word
   localparam int MODE_LORAM  = 0;
   localparam int MODE_HIRAM  = 1;
   localparam int MODE_CHAREN = 2;
   localparam int MODE_GAME   = 3;
   localparam int MODE_EXROM  = 4;

   localparam logic [MODE_W-1:0] MODE_RESET = 5'b11111;

   // top three address bits of the cartridge windows
   localparam logic [2:0] WIN_ROML    = 3'b100;  // 0x8000
   localparam logic [2:0] WIN_ROMH_LO = 3'b101;  // 0xA000
   localparam logic [2:0] WIN_ROMH_HI = 3'b111;  // 0xE000

   typedef enum logic [0:0] {
      CMD_SET_MODE = 1'b0,
      CMD_ACCESS   = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      DEV_RAM    = 3'd0,
      DEV_BASIC  = 3'd1,
      DEV_KERNAL = 3'd2,
      DEV_CHAR   = 3'd3,
      DEV_IO     = 3'd4,
      DEV_NONE   = 3'd5
   } device_type;

   typedef struct packed {
      device_type        device_select;
      logic [ADDR_W-1:0] device_addr;
      logic              romh_sel;
      logic              roml_sel;
      logic [MODE_W-1:0] mode_now;
   } result_type;

   // entry: device code in bits 6:4, base offset in 4 KiB pages in bits 3:0
   localparam logic [7:0] BANK_MAPS [15][16] = '{
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h52, 8'h53, 8'h0C, 8'h30, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h50, 8'h51, 8'h52, 8'h53, 8'h0C, 8'h30, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h40, 8'h0E, 8'h0F},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h52, 8'h53, 8'h0C, 8'h40, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h50, 8'h51, 8'h52, 8'h53, 8'h0C, 8'h40, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h30, 8'h0E, 8'h0F},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h30, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h50, 8'h51, 8'h10, 8'h11, 8'h0C, 8'h30, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h40, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h50, 8'h51, 8'h10, 8'h11, 8'h0C, 8'h40, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h50, 8'h50, 8'h50, 8'h50, 8'h50, 8'h50,
        8'h50, 8'h51, 8'h50, 8'h50, 8'h50, 8'h40, 8'h52, 8'h53},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h10, 8'h11, 8'h0C, 8'h30, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h10, 8'h11, 8'h0C, 8'h40, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h50, 8'h50, 8'h50, 8'h50, 8'h50, 8'h50,
        8'h08, 8'h09, 8'h50, 8'h50, 8'h50, 8'h40, 8'h0E, 8'h0F}
   };

   localparam logic [3:0] READ_MAP_OF_MODE [32] = '{
      4'd0,  4'd0,  4'd1,  4'd2,  4'd0,  4'd3,  4'd4,  4'd5,
      4'd0,  4'd6,  4'd7,  4'd8,  4'd0,  4'd3,  4'd9,  4'd10,
      4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
      4'd0,  4'd6,  4'd7,  4'd12, 4'd0,  4'd3,  4'd9,  4'd13
   };

   localparam logic [3:0] WRITE_MAP_OF_MODE [32] = '{
      4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd3,  4'd3,  4'd3,
      4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd3,  4'd3,  4'd3,
      4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14,
      4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd3,  4'd3,  4'd3
   };

endpackage

FILE: rtl/bank_switch_address_decoder_top.sv
// Bank-switching address decoder.
//
// Request channel (req_valid / req_ready): one item is either a set-mode
// command (req_cmd = 0) that merges req_pins into the banking mode under
// req_mask, or an access (req_cmd = 1) that decodes req_addr through the
// read or write bank table picked by the mode and req_is_write.
// Response channel (rsp_valid / rsp_ready): one item per request, in order:
// device code, device-relative address, cartridge ROMH/ROML decodes and the
// mode after the item.
// Path: input register, then table lookup and compare into the result
// register, where rsp_valid rises; an untaken full result holds the item back.
// Throughput: one item per cycle while results are taken; the lookup reads
// the mode's table select, then its bank entry, between the two registers,
// and the mode register updates as a set-mode item leaves the input register,
// so the next item sees the new mode.
// Reset: both stages empty, mode = all lines high (31).
// Stall: when rsp_ready is low the result register holds; the input register
// still takes one more item, then req_ready drops until the result moves on.
module bank_switch_address_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [0:0]                        req_cmd,
   input  logic [bsad_pkg::MODE_W-1:0]       req_pins,
   input  logic [bsad_pkg::MODE_W-1:0]       req_mask,
   input  logic [bsad_pkg::ADDR_W-1:0]       req_addr,
   input  logic                              req_is_write,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_device_select,
   output logic [bsad_pkg::ADDR_W-1:0]       rsp_device_addr,
   output logic                              rsp_romh_sel,
   output logic                              rsp_roml_sel,
   output logic [bsad_pkg::MODE_W-1:0]       rsp_mode_now
);
   import bsad_pkg::*;

   // input stage
   logic              in_valid_ff;
   logic              in_valid_in;
   cmd_type           cmd_ff;
   logic [MODE_W-1:0] pins_ff;
   logic [MODE_W-1:0] mask_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              is_write_ff;

   // result stage
   logic              out_valid_ff;
   logic              out_valid_in;
   result_type        result_ff;
   result_type        result_in;

   logic              advance;
   logic              take;
   logic [MODE_W-1:0] mode_cur;
   logic [MODE_W-1:0] mode_merged;

   // item moves from input register into result register
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign take      = req_valid & req_ready;

   assign in_valid_in  = take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   bsad_mode u_mode (
      .clock       (clock),
      .reset       (reset),
      .update      (advance && (cmd_ff == CMD_SET_MODE)),
      .pins        (pins_ff),
      .mask        (mask_ff),
      .mode_cur    (mode_cur),
      .mode_merged (mode_merged)
   );

   bsad_decode u_decode (
      .cmd         (cmd_ff),
      .addr        (addr_ff),
      .is_write    (is_write_ff),
      .mode_cur    (mode_cur),
      .mode_merged (mode_merged),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff      <= cmd_type'(req_cmd);
         pins_ff     <= req_pins;
         mask_ff     <= req_mask;
         addr_ff     <= req_addr;
         is_write_ff <= req_is_write;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_device_select = result_ff.device_select;
   assign rsp_device_addr   = result_ff.device_addr;
   assign rsp_romh_sel      = result_ff.romh_sel;
   assign rsp_roml_sel      = result_ff.roml_sel;
   assign rsp_mode_now      = result_ff.mode_now;

endmodule

FILE: rtl/bsad_mode.sv
module bsad_mode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       update,
   input  logic [bsad_pkg::MODE_W-1:0] pins,
   input  logic [bsad_pkg::MODE_W-1:0] mask,
   output logic [bsad_pkg::MODE_W-1:0] mode_cur,
   output logic [bsad_pkg::MODE_W-1:0] mode_merged
);
   import bsad_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   logic [MODE_W-1:0] mode_in;

   assign mode_merged = (mode_ff & ~mask) | (pins & mask);
   assign mode_in     = update ? mode_merged : mode_ff;
   assign mode_cur    = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

FILE: rtl/bsad_decode.sv
module bsad_decode (
   input  bsad_pkg::cmd_type                cmd,
   input  logic [bsad_pkg::ADDR_W-1:0]      addr,
   input  logic                             is_write,
   input  logic [bsad_pkg::MODE_W-1:0]      mode_cur,
   input  logic [bsad_pkg::MODE_W-1:0]      mode_merged,
   output bsad_pkg::result_type             result
);
   import bsad_pkg::*;

   logic [3:0] map_sel;
   logic [7:0] entry;
   logic [2:0] top;
   logic       ultimax;
   logic       romh_hit;
   logic       roml_hit;

   assign top     = addr[15:13];
   // EXROM high, GAME low
   assign ultimax = mode_cur[MODE_EXROM] & ~mode_cur[MODE_GAME];

   always_comb begin
      map_sel  = is_write ? WRITE_MAP_OF_MODE[mode_cur] : READ_MAP_OF_MODE[mode_cur];
      entry    = BANK_MAPS[map_sel][addr[15:12]];
      romh_hit = (mode_cur[MODE_HIRAM] & ~mode_cur[MODE_EXROM] & ~mode_cur[MODE_GAME]
                  & (top == WIN_ROMH_LO))
               | (ultimax & (top == WIN_ROMH_HI));
      roml_hit = (mode_cur[MODE_LORAM] & mode_cur[MODE_HIRAM] & ~mode_cur[MODE_EXROM]
                  & (top == WIN_ROML))
               | (ultimax & (top == WIN_ROML));

      unique case (cmd)
         CMD_SET_MODE: begin
            result.device_select = DEV_NONE;
            result.device_addr   = '0;
            result.romh_sel      = 1'b0;
            result.roml_sel      = 1'b0;
            result.mode_now      = mode_merged;
         end
         CMD_ACCESS: begin
            result.device_select = device_type'(entry[6:4]);
            result.device_addr   = {entry[3:0], addr[11:0]};
            result.romh_sel      = romh_hit;
            result.roml_sel      = roml_hit;
            result.mode_now      = mode_cur;
         end
         default: begin
            result.device_select = DEV_NONE;
            result.device_addr   = '0;
            result.romh_sel      = 1'b0;
            result.roml_sel      = 1'b0;
            result.mode_now      = mode_cur;
         end
      endcase
   end

endmodule

FILE: dv/bank_switch_address_decoder_top_test.sv
`timescale 1ns / 100ps

module bank_switch_address_decoder_top_test;
   import bsad_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RANDOM_ITEMS = 1400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;     // idle time after the last result is checked
   localparam int MAX_REPORTS  = 200;
   localparam int HOLD_AT      = 600;   // results seen before the long stall
   localparam int HOLD_CYCLES  = 400;

   // bank tables: device code in [6:4], base page in [3:0]
   localparam logic [7:0] BANK_TABLE [15][16] = '{
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h52, 8'h53, 8'h0C, 8'h30, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h50, 8'h51, 8'h52, 8'h53, 8'h0C, 8'h30, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h40, 8'h0E, 8'h0F},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h52, 8'h53, 8'h0C, 8'h40, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h50, 8'h51, 8'h52, 8'h53, 8'h0C, 8'h40, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h30, 8'h0E, 8'h0F},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h30, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h50, 8'h51, 8'h10, 8'h11, 8'h0C, 8'h30, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h40, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h50, 8'h51, 8'h10, 8'h11, 8'h0C, 8'h40, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h50, 8'h50, 8'h50, 8'h50, 8'h50, 8'h50,
        8'h50, 8'h51, 8'h50, 8'h50, 8'h50, 8'h40, 8'h52, 8'h53},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h10, 8'h11, 8'h0C, 8'h30, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, 8'h10, 8'h11, 8'h0C, 8'h40, 8'h20, 8'h21},
      '{8'h00, 8'h01, 8'h50, 8'h50, 8'h50, 8'h50, 8'h50, 8'h50,
        8'h08, 8'h09, 8'h50, 8'h50, 8'h50, 8'h40, 8'h0E, 8'h0F}
   };

   // which bank table each mode uses, for reads and for writes
   localparam logic [3:0] READ_TABLE_SEL [32] = '{
      4'd0,  4'd0,  4'd1,  4'd2,  4'd0,  4'd3,  4'd4,  4'd5,
      4'd0,  4'd6,  4'd7,  4'd8,  4'd0,  4'd3,  4'd9,  4'd10,
      4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
      4'd0,  4'd6,  4'd7,  4'd12, 4'd0,  4'd3,  4'd9,  4'd13
   };
   localparam logic [3:0] WRITE_TABLE_SEL [32] = '{
      4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd3,  4'd3,  4'd3,
      4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd3,  4'd3,  4'd3,
      4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14, 4'd14,
      4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd3,  4'd3,  4'd3
   };

   typedef struct {
      cmd_type           cmd;
      logic [MODE_W-1:0] pins;
      logic [MODE_W-1:0] mask;
      logic [ADDR_W-1:0] addr;
      logic              is_write;
   } bus_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // block inputs, all known from time zero
   logic              req_valid    = 1'b0;
   logic [0:0]        req_cmd      = CMD_SET_MODE;
   logic [MODE_W-1:0] req_pins     = '0;
   logic [MODE_W-1:0] req_mask     = '0;
   logic [ADDR_W-1:0] req_addr     = '0;
   logic              req_is_write = 1'b0;
   logic              rsp_ready    = 1'b0;

   logic              req_ready;
   logic              rsp_valid;
   logic [2:0]        rsp_device_select;
   logic [ADDR_W-1:0] rsp_device_addr;
   logic              rsp_romh_sel;
   logic              rsp_roml_sel;
   logic [MODE_W-1:0] rsp_mode_now;

   bus_item_type bus_items[$];        // items still to be offered
   result_type   pending_decodes[$];  // predicted results, oldest first

   logic [MODE_W-1:0] banking_mode = MODE_RESET;

   int  fail_count  = 0;
   int  cycle_count = 0;
   int  items_sent  = 0;
   int  results_got = 0;
   int  req_gap     = 0;
   int  rsp_wait    = 0;
   int  hold_left   = 0;
   bit  hold_done   = 1'b0;
   bit  req_taken   = 1'b0;   // set at the edge an item is accepted
   bit  rsp_taken   = 1'b0;

   bank_switch_address_decoder_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_pins          (req_pins),
      .req_mask          (req_mask),
      .req_addr          (req_addr),
      .req_is_write      (req_is_write),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_device_select (rsp_device_select),
      .rsp_device_addr   (rsp_device_addr),
      .rsp_romh_sel      (rsp_romh_sel),
      .rsp_roml_sel      (rsp_roml_sel),
      .rsp_mode_now      (rsp_mode_now)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Predicts the result of one item and applies a set-mode item to the mode.
   function automatic result_type decode_item(input bus_item_type it);
      result_type        r;
      logic [3:0]        table_sel;
      logic [7:0]        entry;
      logic [2:0]        top;
      logic [MODE_W-1:0] m;
      if (it.cmd == CMD_SET_MODE) begin
         banking_mode    = (banking_mode & ~it.mask) | (it.pins & it.mask);
         r.device_select = DEV_NONE;
         r.device_addr   = '0;
         r.romh_sel      = 1'b0;
         r.roml_sel      = 1'b0;
      end else begin
         m         = banking_mode;
         table_sel = it.is_write ? WRITE_TABLE_SEL[m] : READ_TABLE_SEL[m];
         entry     = BANK_TABLE[table_sel][it.addr[15:12]];
         top       = it.addr[15:13];
         r.device_select = device_type'(entry[6:4]);
         r.device_addr   = {entry[3:0], it.addr[11:0]};
         // ROMH: 16K game mode at 0xA000, or ultimax at 0xE000
         r.romh_sel = (m[MODE_HIRAM] && !m[MODE_GAME] && !m[MODE_EXROM] &&
                       top == WIN_ROMH_LO) ||
                      (m[MODE_EXROM] && !m[MODE_GAME] && top == WIN_ROMH_HI);
         // ROML: LORAM and HIRAM with EXROM low, or ultimax, at 0x8000
         r.roml_sel = ((m[MODE_LORAM] && m[MODE_HIRAM] && !m[MODE_EXROM]) ||
                       (m[MODE_EXROM] && !m[MODE_GAME])) && top == WIN_ROML;
      end
      r.mode_now = banking_mode;
      return r;
   endfunction

   // Idle cycles after one item; zero during quiet stretches.
   function automatic int draw_wait(input bit quiet);
      if (quiet || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 17);
   endfunction

   task automatic add_item(input cmd_type cmd, input logic [MODE_W-1:0] pins,
                           input logic [MODE_W-1:0] mask,
                           input logic [ADDR_W-1:0] addr, input logic is_write);
      bus_item_type it;
      it.cmd      = cmd;
      it.pins     = pins;
      it.mask     = mask;
      it.addr     = addr;
      it.is_write = is_write;
      bus_items.push_back(it);
   endtask

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0h, got %0h",
                     $time, name, exp_val, act_val);
      end
   endtask

   // Sender: new item or idle noise at the falling edge, one update per signal.
   always @(negedge clock) begin : drive_requests
      bus_item_type it;
      logic         valid_next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         valid_next = req_valid;
         if (req_taken) begin
            req_taken  = 1'b0;
            valid_next = 1'b0;
            // keep offering while the receiver is held off
            req_gap = draw_wait(hold_left > 0 || (items_sent % 300) >= 220);
         end
         if (!valid_next) begin
            if (req_gap > 0 || bus_items.size() == 0) begin
               if (req_gap > 0)
                  req_gap--;
               req_cmd      <= cmd_type'($urandom_range(0, 1));
               req_pins     <= MODE_W'($urandom);
               req_mask     <= MODE_W'($urandom);
               req_addr     <= ADDR_W'($urandom);
               req_is_write <= 1'($urandom);
            end else begin
               it = bus_items.pop_front();
               req_cmd      <= it.cmd;
               req_pins     <= it.pins;
               req_mask     <= it.mask;
               req_addr     <= it.addr;
               req_is_write <= it.is_write;
               valid_next   = 1'b1;
            end
         end
         req_valid <= valid_next;
      end
   end

   // Receiver: waits a drawn number of cycles after each result.
   always @(negedge clock) begin : drive_ready
      logic ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_wait  = draw_wait(((results_got + 150) % 300) >= 220);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         if (hold_left > 0)
            ready_next = 1'b0;
         rsp_ready <= ready_next;
      end
   end

   // One long receiver stall so the block fills and pushes back on the sender.
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
         end else if (!hold_done && results_got >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
      end
   end

   // Monitor: predicts on request acceptance, checks on result acceptance.
   always @(posedge clock) begin : watch_channels
      result_type   exp_r;
      bus_item_type it;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            results_got++;
            if (pending_decodes.size() == 0) begin
               fail_count++;
               $display("%0t: result with none expected: device %0h addr %0h mode %0h",
                        $time, rsp_device_select, rsp_device_addr, rsp_mode_now);
            end else begin
               exp_r = pending_decodes.pop_front();
               check_field("device_select", exp_r.device_select, rsp_device_select);
               check_field("device_addr", exp_r.device_addr, rsp_device_addr);
               check_field("romh_sel", exp_r.romh_sel, rsp_romh_sel);
               check_field("roml_sel", exp_r.roml_sel, rsp_roml_sel);
               check_field("mode_now", exp_r.mode_now, rsp_mode_now);
            end
         end
         if (req_valid && req_ready) begin
            req_taken   = 1'b1;
            items_sent++;
            it.cmd      = cmd_type'(req_cmd);
            it.pins     = req_pins;
            it.mask     = req_mask;
            it.addr     = req_addr;
            it.is_write = req_is_write;
            pending_decodes.push_back(decode_item(it));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still due", $time, pending_decodes.size());
         $display("** bank_switch_address_decoder_top: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      logic [ADDR_W-1:0] a;
      // directed: reset mode, table extremes, cartridge windows
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'h0000, 1'b0);
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'hFFFF, 1'b0);
      add_item(CMD_ACCESS,   5'h1F, 5'h1F, 16'hFFFF, 1'b1);
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'hA000, 1'b0);
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'hD000, 1'b0);
      add_item(CMD_SET_MODE, 5'h00, 5'h00, 16'hFFFF, 1'b1);  // empty mask, no change
      add_item(CMD_SET_MODE, 5'h00, 5'h1F, 16'h0000, 1'b0);  // all lines low
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'h8000, 1'b0);
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'hFFFF, 1'b1);
      add_item(CMD_SET_MODE, 5'h10, 5'h1F, 16'h0000, 1'b0);  // ultimax
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'h8000, 1'b0);
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'hE000, 1'b0);
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'h1000, 1'b1);
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'h2FFF, 1'b0);
      add_item(CMD_SET_MODE, 5'h03, 5'h1F, 16'h0000, 1'b0);  // 16K game mode
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'h8000, 1'b0);
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'hA000, 1'b0);
      add_item(CMD_SET_MODE, 5'h08, 5'h08, 16'h0000, 1'b0);  // partial mask
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'hA123, 1'b0);
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'h9FFF, 1'b1);
      add_item(CMD_SET_MODE, 5'h1F, 5'h15, 16'h0000, 1'b0);  // back to all high
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'hE000, 1'b1);
      add_item(CMD_ACCESS,   5'h00, 5'h00, 16'h0FFF, 1'b0);

      // random: mode changes mixed into runs of accesses
      repeat (RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 3) begin
            add_item(CMD_SET_MODE, MODE_W'($urandom),
                     ($urandom_range(0, 3) == 0) ? 5'h1F : MODE_W'($urandom),
                     ADDR_W'($urandom), 1'($urandom));
         end else begin
            a = ADDR_W'($urandom);
            // bank edges now and then
            if ($urandom_range(0, 3) == 0)
               a[11:0] = ($urandom_range(0, 1) == 0) ? 12'h000 : 12'hFFF;
            add_item(CMD_ACCESS, MODE_W'($urandom), MODE_W'($urandom), a, 1'($urandom));
         end
      end

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      while (bus_items.size() != 0 || req_valid)
         @(posedge clock);
      while (pending_decodes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("** bank_switch_address_decoder_top: PASSED **");
      end else begin
         $display("** bank_switch_address_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule
